// ----- sv/satl_pkg.sv -----
// Package for the set-associative tag lookup core.
// Holds geometry constants, config register indexes, FSM state and ctrl/datapath structs.
// No dependencies.
`default_nettype none
package satl_pkg;

    localparam int ADDR_W      = 32;
    localparam int MAX_ENTRIES = 256;
    localparam int MAX_WAYS    = 8;
    localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
    localparam int LANE_W      = $clog2(MAX_WAYS);
    localparam int ROWS        = MAX_ENTRIES / MAX_WAYS;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int TAG_W       = ADDR_W;

    localparam int ELOG_W      = 4;
    localparam int WLOG_W      = 2;
    localparam int EMAX        = ENTRY_W;
    localparam int WMAX        = LANE_W;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ENTRIES_LOG2 = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_WAYS_LOG2    = t_cfg_idx'(1);

    localparam logic [ELOG_W-1:0] ENTRIES_LOG2_RST = ELOG_W'(8);
    localparam logic [WLOG_W-1:0] WAYS_LOG2_RST    = WLOG_W'(0);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CMP
    } t_state;

    typedef struct packed {
        logic start;   // beat accepted, launch tag row read
        logic commit;  // compare done, update store and load result
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ----- sv/satl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module satl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- sv/satl_ctrl.sv -----
// Controller FSM for the tag lookup core: read phase, then compare/fill phase.
// Depends on satl_pkg.
`default_nettype none
module satl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire satl_pkg::t_stat i_stat,
    output satl_pkg::t_cmd     o_cmd
);
    import satl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/satl_dp.sv -----
// Datapath: config registers, valid flops, per-way tag RAM banks, compare and fill.
// Depends on satl_pkg and satl_ram.
`default_nettype none
module satl_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire satl_pkg::t_cmd                 i_cmd,
    output satl_pkg::t_stat                     o_stat,
    input  wire logic [satl_pkg::ADDR_W-1:0]    i_address,
    input  wire logic                           i_cfg_valid,
    input  wire satl_pkg::t_cfg_idx             i_cfg_index,
    input  wire logic [satl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_hit
);
    import satl_pkg::*;

    logic [ELOG_W-1:0]  r_entries_log2;
    logic [WLOG_W-1:0]  r_ways_log2;
    logic [ELOG_W-1:0]  e_eff;
    logic [ELOG_W-1:0]  w_sat;
    logic [ELOG_W-1:0]  w_eff;
    logic [ENTRY_W:0]   emask_full;
    logic [ENTRY_W-1:0] emask;
    logic [LANE_W:0]    wmask_full;
    logic [LANE_W-1:0]  wmask;

    logic [ADDR_W-1:0]  r_addr;
    logic [ENTRY_W-1:0] in_base;
    logic [ENTRY_W-1:0] base;
    logic [ROW_W-1:0]   row;
    logic [LANE_W-1:0]  grp;
    logic [TAG_W-1:0]   tag;

    logic [TAG_W-1:0]   rd_tag [MAX_WAYS];
    logic [MAX_WAYS-1:0] r_valid [ROWS];
    logic [MAX_WAYS-1:0] row_valid;
    logic [MAX_WAYS-1:0] in_grp;
    logic [MAX_WAYS-1:0] lane_hit;
    logic               hit;
    logic               found;
    logic [LANE_W-1:0]  victim;

    logic r_out_valid;
    logic r_hit;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_log2 <= ENTRIES_LOG2_RST;
            r_ways_log2    <= WAYS_LOG2_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENTRIES_LOG2: r_entries_log2 <= i_cfg_data[ELOG_W-1:0];
                CFG_WAYS_LOG2:    r_ways_log2    <= i_cfg_data[WLOG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry, saturated
    always_comb begin
        e_eff = (r_entries_log2 > ELOG_W'(EMAX)) ? ELOG_W'(EMAX) : r_entries_log2;
        w_sat = (ELOG_W'(r_ways_log2) > ELOG_W'(WMAX)) ? ELOG_W'(WMAX)
                                                        : ELOG_W'(r_ways_log2);
        w_eff = (w_sat > e_eff) ? e_eff : w_sat;
        emask_full = (ENTRY_W+1)'((ENTRY_W+1)'(1) << e_eff) - (ENTRY_W+1)'(1);
        emask      = emask_full[ENTRY_W-1:0];
        wmask_full = (LANE_W+1)'((LANE_W+1)'(1) << w_eff) - (LANE_W+1)'(1);
        wmask      = wmask_full[LANE_W-1:0];
    end

    // base entry of the set: address low bits masked to entries, way bits cleared
    assign in_base = i_address[ENTRY_W-1:0] & emask & {{(ENTRY_W-LANE_W){1'b1}}, ~wmask};
    assign base    = r_addr[ENTRY_W-1:0] & emask & {{(ENTRY_W-LANE_W){1'b1}}, ~wmask};
    assign row     = base[ENTRY_W-1:LANE_W];
    assign grp     = base[LANE_W-1:0];
    assign tag     = r_addr >> e_eff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= i_address;
        end
    end

    for (genvar l = 0; l < MAX_WAYS; l++) begin : g_bank
        satl_ram #(
            .WIDTH (TAG_W),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.commit && !hit && (victim == LANE_W'(l))),
            .i_waddr (row),
            .i_wdata (tag),
            .i_re    (i_cmd.start),
            .i_raddr (in_base[ENTRY_W-1:LANE_W]),
            .o_rdata (rd_tag[l])
        );
    end

    assign row_valid = r_valid[row];

    always_comb begin
        for (int l = 0; l < MAX_WAYS; l++) begin
            in_grp[l]   = ((LANE_W'(l) & ~wmask) == grp);
            lane_hit[l] = in_grp[l] && row_valid[l] && (rd_tag[l] == tag);
        end
        hit = |lane_hit;
    end

    always_comb begin
        found  = 1'b0;
        victim = grp;
        for (int l = 0; l < MAX_WAYS; l++) begin
            if (!found && in_grp[l] && !row_valid[l]) begin
                found  = 1'b1;
                victim = LANE_W'(l);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_valid[r] <= '0;
            end
        end else if (i_cmd.commit && !hit) begin
            r_valid[row][victim] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit <= hit;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;

endmodule
`default_nettype wire

// ----- sv/set_assoc_cache_tag_lookup_core.sv -----
// Set-associative tag lookup core: hit/miss per address beat, fill on miss.
// Timing: the tag RAM is read on the accepting edge, compare/fill follows in the compare
// state, and the result register loads when the compare commits. The next beat is accepted
// only after the previous one commits; the commit stalls while the result register is still
// held. Synchronous active-low reset clears all valid bits at once (no clearing sweep) and
// restores entries_log2=8, ways_log2=0.
// Depends on satl_pkg, satl_ctrl, satl_dp, satl_ram.
`default_nettype none
module set_assoc_cache_tag_lookup_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [satl_pkg::ADDR_W-1:0]     i_address,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_hit,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [satl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [satl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import satl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    satl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    satl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_address   (i_address),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hit       (o_hit)
    );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for set_assoc_cache_tag_lookup_core: a directed table of lookups and register
// writes, then random phases; hit/miss beats are checked against the table or a local tag store.
// Depends on satl_pkg and the core RTL.
module testbench;
    import satl_pkg::*;

    localparam logic MISS = 1'b0;
    localparam logic HIT  = 1'b1;
    localparam t_cfg_idx CFG_UNMAPPED = t_cfg_idx'(15);
    localparam int STALL_LIMIT = 400;
    localparam int DRAIN_PAUSE = 4;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int POOL        = 16;

    typedef struct packed {
        logic                  is_cfg;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [ADDR_W-1:0]     addr;
        logic                  typed;
        logic                  typed_hit;
    } t_row;

    localparam int PLAN_LEN = 26;
    localparam t_row PLAN [PLAN_LEN] = '{
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0000, 1'b1, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0000, 1'b1, HIT },
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'hFFFF_FFFF, 1'b1, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'hFFFF_FFFF, 1'b1, HIT },
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0100, 1'b1, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0000, 1'b1, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h8000_0000, 1'b1, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h5555_5555, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'hAAAA_AAAA, 1'b0, MISS},
        // oversized entry count saturates; store kept across the change
        '{1'b1, CFG_ENTRIES_LOG2, 4'hF, 32'h0000_0000, 1'b0, MISS},
        '{1'b1, CFG_WAYS_LOG2,    4'hF, 32'h0000_0000, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0000, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0000, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0100, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0200, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0800, 1'b0, MISS},
        // ways above entries: one set
        '{1'b1, CFG_ENTRIES_LOG2, 4'h1, 32'h0000_0000, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0002, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0004, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'hFFFF_FFFE, 1'b0, MISS},
        '{1'b1, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0000, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0001, 1'b0, MISS},
        '{1'b0, CFG_ENTRIES_LOG2, 4'h0, 32'h0000_0001, 1'b0, MISS},
        '{1'b1, CFG_UNMAPPED,     4'hA, 32'h0000_0000, 1'b0, MISS},
        '{1'b1, CFG_WAYS_LOG2,    4'h0, 32'h0000_0000, 1'b0, MISS},
        '{1'b1, CFG_ENTRIES_LOG2, 4'h8, 32'h0000_0000, 1'b0, MISS}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [ADDR_W-1:0]     i_address   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    t_cfg_idx              i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_hit;
    logic                  o_cfg_ready;

    logic [ELOG_W-1:0] model_entries_log2;
    logic [WLOG_W-1:0] model_ways_log2;
    logic              line_valid [MAX_ENTRIES];
    logic [TAG_W-1:0]  line_tag   [MAX_ENTRIES];

    logic expected_hits [$];
    logic beat_typed     = 1'b0;
    logic beat_typed_hit = MISS;
    logic predicted;
    logic want;
    int   mismatches  = 0;
    int   idle_cycles = 0;
    int   sink_wait   = 0;
    int   stall;
    bit   no_gaps     = 1'b0;

    set_assoc_cache_tag_lookup_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_address   (i_address),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_hit       (o_hit),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic lookup_and_fill(input logic [ADDR_W-1:0] addr);
        int unsigned e, w, base, idx;
        int          victim;
        logic [ADDR_W-1:0] set_no, tag;
        e = (model_entries_log2 > EMAX) ? EMAX : model_entries_log2;
        w = (model_ways_log2 > WMAX) ? WMAX : model_ways_log2;
        if (w > e) w = e;
        set_no = (addr >> w) & ((ADDR_W'(1) << (e - w)) - 1);
        tag    = addr >> e;
        base   = set_no << w;
        victim = -1;
        for (int k = 0; k < (1 << w); k++) begin
            idx = (base + k) % MAX_ENTRIES;
            if (line_valid[idx] && line_tag[idx] == tag) return HIT;
        end
        for (int k = 0; k < (1 << w); k++) begin
            idx = (base + k) % MAX_ENTRIES;
            if (!line_valid[idx] && victim < 0) victim = idx;
        end
        if (victim < 0) victim = base % MAX_ENTRIES;
        line_tag[victim]   = tag;
        line_valid[victim] = 1'b1;
        return MISS;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // track config and lookups as the core accepts them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_entries_log2 = ENTRIES_LOG2_RST;
            model_ways_log2    = WAYS_LOG2_RST;
            for (int i = 0; i < MAX_ENTRIES; i++) line_valid[i] = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ENTRIES_LOG2)
                    model_entries_log2 = i_cfg_data[ELOG_W-1:0];
                else if (i_cfg_index == CFG_WAYS_LOG2)
                    model_ways_log2 = i_cfg_data[WLOG_W-1:0];
            end
            if (i_in_valid && o_in_ready) begin
                predicted = lookup_and_fill(i_address);
                expected_hits.push_back(beat_typed ? beat_typed_hit : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_hits.size() == 0) begin
                flag_mismatch("result beat with no lookup pending");
            end else begin
                want = expected_hits.pop_front();
                if (o_hit !== want)
                    flag_mismatch($sformatf("hit=%b, expected %b", o_hit, want));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_wait   <= 0;
        end else if (o_out_valid && i_out_ready) begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            sink_wait   <= stall;
            i_out_ready <= (stall == 0);
        end else if (sink_wait != 0) begin
            sink_wait   <= sink_wait - 1;
            i_out_ready <= (sink_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic typed,
                               input logic typed_hit);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_address      <= addr;
        beat_typed     <= typed;
        beat_typed_hit <= typed_hit;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // registers change only with the core drained
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (expected_hits.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin
        logic [ADDR_W-1:0]     recent [POOL];
        logic [ADDR_W-1:0]     addr;
        logic [ADDR_W-1:0]     low_mask;
        logic [CFG_DATA_W-1:0] e_raw;
        logic [CFG_DATA_W-1:0] w_raw;
        int unsigned           e_set;
        int unsigned           pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PLAN[r]) begin
            if (PLAN[r].is_cfg)
                write_reg(PLAN[r].reg_idx, PLAN[r].reg_data);
            else
                send_lookup(PLAN[r].addr, PLAN[r].typed, PLAN[r].typed_hit);
        end

        foreach (recent[k]) recent[k] = $urandom;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            e_raw = (ph == 0) ? 4'd8 : (ph == 1) ? 4'd0 : 4'($urandom_range(0, 15));
            w_raw = 4'($urandom);
            if (ph == 0) w_raw[1:0] = 2'd3;
            if (ph == 1) w_raw[1:0] = 2'd0;
            write_reg(CFG_ENTRIES_LOG2, e_raw);
            write_reg(CFG_WAYS_LOG2, w_raw);
            no_gaps  = (ph % 4 == 3);
            e_set    = (e_raw > EMAX) ? EMAX : e_raw;
            low_mask = (ADDR_W'(1) << e_set) - 1;
            repeat (PHASE_ITEMS) begin
                // mostly reuse or conflict on recent addresses so hits and evictions occur
                pick = $urandom_range(0, 9);
                addr = recent[$urandom_range(0, POOL - 1)];
                if (pick >= 8)
                    addr = $urandom;
                else if (pick >= 5)
                    addr = (addr & low_mask) | (ADDR_W'($urandom) & ~low_mask);
                recent[$urandom_range(0, POOL - 1)] = addr;
                send_lookup(addr, 1'b0, MISS);
            end
        end

        no_gaps = 1'b0;
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (expected_hits.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
sv/satl_pkg.sv
sv/satl_ram.sv
sv/satl_ctrl.sv
sv/satl_dp.sv
sv/set_assoc_cache_tag_lookup_core.sv
tb/testbench.sv
